>>> design/cfp_pkg.sv
`timescale 1ns / 1ps
package cfp_pkg;

    localparam int FLAGS_DEFAULT   = 8;
    localparam int MAX_LEN_DEFAULT = 4096;
    localparam int TABLE_SLOTS     = 8;
    localparam int INDEX_W         = 3;
    localparam int CHAR_W          = 8;
    localparam int CFG_W           = 64;
    localparam int MASK_W          = 8;

    localparam logic [CHAR_W-1:0] CHAR_NUL    = 8'h00;
    localparam logic [CHAR_W-1:0] CHAR_TAB    = 8'h09;
    localparam logic [CHAR_W-1:0] CHAR_CR     = 8'h0d;
    localparam logic [CHAR_W-1:0] CHAR_SPACE  = 8'h20;
    localparam logic [CHAR_W-1:0] CHAR_DQUOTE = 8'h22;
    localparam logic [CHAR_W-1:0] CHAR_SQUOTE = 8'h27;
    localparam logic [CHAR_W-1:0] CHAR_DASH   = 8'h2d;
    localparam logic [CHAR_W-1:0] CHAR_BSLASH = 8'h5c;

    localparam logic CFG_FLAG_CHARS = 1'b0;
    localparam logic CFG_ALLOW_MASK = 1'b1;

    typedef enum logic [1:0] {
        OP_HIT,
        OP_ARG_QUOTED,
        OP_ARG_PLAIN,
        OP_GROW
    } rec_op_t;

    function automatic logic is_space(input logic [CHAR_W-1:0] c);
        return (c == CHAR_SPACE) || ((c >= CHAR_TAB) && (c <= CHAR_CR));
    endfunction

    function automatic logic is_quote(input logic [CHAR_W-1:0] c);
        return (c == CHAR_DQUOTE) || (c == CHAR_SQUOTE);
    endfunction

endpackage

>>> design/command_flag_parser.sv
`timescale 1ns / 1ps
// a character's record update is read in the accept cycle and written back in the next
// cycle; throughput is one character per cycle while ch_stall is low, set by the single
// read-modify-write on the flag record memory. a zero character starts a report walk over
// that memory: each entry is read, then loaded into the output register; ch_stall stays high.
// reset (rst_n, asynchronous): clears configuration, parse state and the record valid bits;
// the memory itself is never swept, an entry with its valid bit low reads as all zero.
module command_flag_parser #(
    parameter int FLAGS   = cfp_pkg::FLAGS_DEFAULT,
    parameter int MAX_LEN = cfp_pkg::MAX_LEN_DEFAULT,
    localparam int POS_W  = $clog2(MAX_LEN + 1)
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       ch_valid,
    output logic                       ch_stall,
    input  logic [cfp_pkg::CHAR_W-1:0] ch,
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic                       cfg_index,
    input  logic [cfp_pkg::CFG_W-1:0]  cfg_data,
    output logic                       report_valid,
    input  logic                       report_stall,
    output logic                       entry_valid,
    output logic [cfp_pkg::INDEX_W-1:0] entry_index,
    output logic                       present,
    output logic                       duplicated,
    output logic                       escaped_quote,
    output logic                       arg_given,
    output logic [POS_W-1:0]           arg_start,
    output logic [POS_W-1:0]           arg_length,
    output logic [POS_W-1:0]           stop_position,
    output logic                       length_overflow,
    output logic                       last_report
);

    localparam int AW        = (FLAGS > 1) ? $clog2(FLAGS) : 1;
    localparam int REC_W     = 4 + 2 * POS_W;
    localparam int B_PRESENT = REC_W - 1;
    localparam int B_DUP     = REC_W - 2;
    localparam int B_ESC     = REC_W - 3;
    localparam int B_GIVEN   = REC_W - 4;
    localparam logic [POS_W-1:0] MAX_POS = POS_W'(MAX_LEN);

    typedef enum logic [2:0] {
        PH_SEEK,
        PH_FLAG,
        PH_ARGSEEK,
        PH_ARG,
        PH_ESC,
        PH_STOP
    } phase_t;

    typedef enum logic [1:0] {
        Q_NONE,
        Q_DOUBLE,
        Q_SINGLE
    } quote_t;

    typedef enum logic [1:0] {
        ST_RUN,
        ST_READ,
        ST_LOAD
    } walk_t;

    // configuration
    logic [cfp_pkg::CFG_W-1:0]  flag_chars_reg;
    logic [cfp_pkg::MASK_W-1:0] allow_mask_reg;

    // parse control
    phase_t           phase_reg, phase_next;
    quote_t           quote_reg, quote_next;
    logic [AW-1:0]    owner_reg, owner_next;
    logic [POS_W-1:0] pos_reg, pos_next;
    logic [POS_W-1:0] stopped_reg, stopped_next;
    logic             ovf_reg, ovf_next;

    // record update stage
    logic                 op_valid_reg;
    cfp_pkg::rec_op_t     op_kind_reg, op_kind;
    logic [AW-1:0]        op_addr_reg, op_addr;
    logic                 op_esc_reg, op_esc;
    logic [POS_W-1:0]     op_pos_reg, op_pos;
    logic                 op_fire;
    logic                 fwd_hit_reg;
    logic [REC_W-1:0]     fwd_data_reg;
    logic [FLAGS-1:0]     vbit_reg;

    // report walk
    walk_t            state_reg;
    logic [AW-1:0]    walk_idx_reg;
    logic [AW-1:0]    rpt_last_reg;
    logic             rpt_empty_reg;
    logic [POS_W-1:0] rpt_stop_reg;
    logic             rpt_ovf_reg;

    // output register
    logic                        report_valid_reg;
    logic                        entry_valid_reg;
    logic [cfp_pkg::INDEX_W-1:0] entry_index_reg;
    logic [REC_W-1:0]            out_rec_reg;
    logic [POS_W-1:0]            stop_position_reg;
    logic                        length_overflow_reg;
    logic                        last_report_reg;

    logic ch_take;
    logic is_term;
    logic is_sp;
    logic is_q;
    logic is_dash;
    logic at_limit;
    logic [POS_W-1:0] pos_plus;

    logic [cfp_pkg::TABLE_SLOTS-1:0] slot_active;
    logic [cfp_pkg::TABLE_SLOTS-1:0] slot_hit;
    logic                            live;
    logic [cfp_pkg::INDEX_W-1:0]     hit_idx;
    logic [cfp_pkg::INDEX_W-1:0]     last_idx;
    logic                            hit_any;

    logic             ram_re;
    logic [AW-1:0]    ram_raddr;
    logic [REC_W-1:0] ram_rdata;
    logic [REC_W-1:0] rec_old;
    logic [REC_W-1:0] rec_new;
    logic [POS_W-1:0] len_grown;
    logic [REC_W-1:0] walk_rec;
    logic             walk_last;
    logic             out_free;

    assign ch_stall  = (state_reg != ST_RUN);
    assign cfg_ready = 1'b1;
    assign ch_take   = ch_valid && !ch_stall;
    assign is_term   = (ch == cfp_pkg::CHAR_NUL);
    assign is_sp     = cfp_pkg::is_space(ch);
    assign is_q      = cfp_pkg::is_quote(ch);
    assign is_dash   = (ch == cfp_pkg::CHAR_DASH);
    assign at_limit  = (pos_reg == MAX_POS);
    assign pos_plus  = at_limit ? MAX_POS : pos_reg + 1'b1;

    // table decode: entries up to the first zero byte, capped at FLAGS
    always_comb
    begin
        live     = 1'b1;
        hit_idx  = '0;
        last_idx = '0;
        for (int k = 0; k < cfp_pkg::TABLE_SLOTS; k++)
        begin
            live = live && (k < FLAGS) && (flag_chars_reg[8*k +: 8] != cfp_pkg::CHAR_NUL);
            slot_active[k] = live;
            slot_hit[k]    = live && (flag_chars_reg[8*k +: 8] == ch);
            if (live)
            begin
                last_idx = cfp_pkg::INDEX_W'(k);
            end
        end
        for (int k = cfp_pkg::TABLE_SLOTS - 1; k >= 0; k--)
        begin
            if (slot_hit[k])
            begin
                hit_idx = cfp_pkg::INDEX_W'(k);
            end
        end
        hit_any = |slot_hit;
    end

    // parse control and record request
    always_comb
    begin
        phase_next   = phase_reg;
        quote_next   = quote_reg;
        owner_next   = owner_reg;
        pos_next     = pos_reg;
        stopped_next = stopped_reg;
        ovf_next     = ovf_reg;
        op_fire      = 1'b0;
        op_kind      = cfp_pkg::OP_GROW;
        op_addr      = owner_reg;
        op_esc       = 1'b0;
        op_pos       = pos_reg;
        if (ch_take)
        begin
            if (is_term)
            begin
                phase_next   = PH_SEEK;
                quote_next   = Q_NONE;
                owner_next   = '0;
                pos_next     = '0;
                stopped_next = '0;
                ovf_next     = 1'b0;
            end
            else
            begin
                pos_next = pos_plus;
                if (at_limit)
                begin
                    ovf_next = 1'b1;
                end
                unique case (phase_reg)
                    PH_SEEK:
                    begin
                        if (!is_sp)
                        begin
                            if (is_dash)
                            begin
                                phase_next = PH_FLAG;
                            end
                            else
                            begin
                                stopped_next = pos_reg;
                                phase_next   = PH_STOP;
                            end
                        end
                    end
                    PH_FLAG:
                    begin
                        priority if (is_sp)
                        begin
                            phase_next = PH_SEEK;
                        end
                        else if (is_q)
                        begin
                            stopped_next = pos_reg;
                            phase_next   = PH_STOP;
                        end
                        else if (!is_dash && hit_any)
                        begin
                            op_fire = 1'b1;
                            op_kind = cfp_pkg::OP_HIT;
                            op_addr = hit_idx[AW-1:0];
                            if (allow_mask_reg[hit_idx])
                            begin
                                owner_next = hit_idx[AW-1:0];
                                phase_next = PH_ARGSEEK;
                            end
                        end
                    end
                    PH_ARGSEEK:
                    begin
                        if (!is_sp)
                        begin
                            if (is_dash)
                            begin
                                phase_next = PH_FLAG;
                            end
                            else
                            begin
                                op_fire    = 1'b1;
                                phase_next = PH_ARG;
                                if (is_q)
                                begin
                                    quote_next = (ch == cfp_pkg::CHAR_DQUOTE) ? Q_DOUBLE
                                                                               : Q_SINGLE;
                                    op_kind    = cfp_pkg::OP_ARG_QUOTED;
                                    op_pos     = pos_plus;
                                end
                                else
                                begin
                                    quote_next = Q_NONE;
                                    op_kind    = cfp_pkg::OP_ARG_PLAIN;
                                end
                            end
                        end
                    end
                    PH_ARG:
                    begin
                        if (quote_reg == Q_NONE)
                        begin
                            priority if (is_sp)
                            begin
                                phase_next = PH_SEEK;
                            end
                            else if (is_dash)
                            begin
                                phase_next = PH_FLAG;
                            end
                            else
                            begin
                                op_fire = 1'b1;
                            end
                        end
                        else if (ch == ((quote_reg == Q_DOUBLE) ? cfp_pkg::CHAR_DQUOTE
                                                                : cfp_pkg::CHAR_SQUOTE))
                        begin
                            phase_next = PH_FLAG;
                        end
                        else
                        begin
                            op_fire = 1'b1;
                            if (ch == cfp_pkg::CHAR_BSLASH)
                            begin
                                phase_next = PH_ESC;
                            end
                        end
                    end
                    PH_ESC:
                    begin
                        op_fire    = 1'b1;
                        op_esc     = is_q;
                        phase_next = PH_ARG;
                    end
                    PH_STOP:
                    begin
                    end
                    default:
                    begin
                        phase_next = PH_STOP;
                    end
                endcase
            end
        end
    end

    assign ram_re    = (state_reg == ST_READ) || op_fire;
    assign ram_raddr = (state_reg == ST_RUN) ? op_addr : walk_idx_reg;

    cfp_ram #(
        .WIDTH (REC_W),
        .DEPTH (FLAGS)
    ) u_rec_ram (
        .clk   (clk),
        .we    (op_valid_reg),
        .waddr (op_addr_reg),
        .wdata (rec_new),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // modify stage: forward the previous write when it hit the same entry
    always_comb
    begin
        if (fwd_hit_reg)
        begin
            rec_old = fwd_data_reg;
        end
        else if (vbit_reg[op_addr_reg])
        begin
            rec_old = ram_rdata;
        end
        else
        begin
            rec_old = '0;
        end
        len_grown = (rec_old[POS_W-1:0] == MAX_POS) ? MAX_POS : rec_old[POS_W-1:0] + 1'b1;
        rec_new   = rec_old;
        unique case (op_kind_reg)
            cfp_pkg::OP_HIT:
            begin
                if (rec_old[B_PRESENT])
                begin
                    rec_new             = '0;
                    rec_new[B_PRESENT]  = 1'b1;
                    rec_new[B_DUP]      = 1'b1;
                end
                else
                begin
                    rec_new[B_PRESENT] = 1'b1;
                end
            end
            cfp_pkg::OP_ARG_QUOTED:
            begin
                rec_new[B_GIVEN]               = 1'b1;
                rec_new[2*POS_W-1:POS_W]       = op_pos_reg;
            end
            cfp_pkg::OP_ARG_PLAIN:
            begin
                rec_new[B_GIVEN]               = 1'b1;
                rec_new[2*POS_W-1:POS_W]       = op_pos_reg;
                rec_new[POS_W-1:0]             = len_grown;
            end
            cfp_pkg::OP_GROW:
            begin
                rec_new[POS_W-1:0] = len_grown;
                if (op_esc_reg)
                begin
                    rec_new[B_ESC] = 1'b1;
                end
            end
            default:
            begin
                rec_new = rec_old;
            end
        endcase
    end

    assign walk_rec  = (rpt_empty_reg || !vbit_reg[walk_idx_reg]) ? '0 : ram_rdata;
    assign walk_last = rpt_empty_reg || (walk_idx_reg == rpt_last_reg);
    assign out_free  = !report_valid_reg || !report_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            flag_chars_reg      <= '0;
            allow_mask_reg      <= '0;
            phase_reg           <= PH_SEEK;
            quote_reg           <= Q_NONE;
            owner_reg           <= '0;
            pos_reg             <= '0;
            stopped_reg         <= '0;
            ovf_reg             <= 1'b0;
            op_valid_reg        <= 1'b0;
            op_kind_reg         <= cfp_pkg::OP_GROW;
            op_addr_reg         <= '0;
            op_esc_reg          <= 1'b0;
            op_pos_reg          <= '0;
            fwd_hit_reg         <= 1'b0;
            fwd_data_reg        <= '0;
            vbit_reg            <= '0;
            state_reg           <= ST_RUN;
            walk_idx_reg        <= '0;
            rpt_last_reg        <= '0;
            rpt_empty_reg       <= 1'b0;
            rpt_stop_reg        <= '0;
            rpt_ovf_reg         <= 1'b0;
            report_valid_reg    <= 1'b0;
            entry_valid_reg     <= 1'b0;
            entry_index_reg     <= '0;
            out_rec_reg         <= '0;
            stop_position_reg   <= '0;
            length_overflow_reg <= 1'b0;
            last_report_reg     <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_index)
                    cfp_pkg::CFG_FLAG_CHARS: flag_chars_reg <= cfg_data;
                    cfp_pkg::CFG_ALLOW_MASK: allow_mask_reg <= cfg_data[cfp_pkg::MASK_W-1:0];
                    default:                 flag_chars_reg <= flag_chars_reg;
                endcase
            end

            phase_reg   <= phase_next;
            quote_reg   <= quote_next;
            owner_reg   <= owner_next;
            pos_reg     <= pos_next;
            stopped_reg <= stopped_next;
            ovf_reg     <= ovf_next;

            op_valid_reg <= op_fire;
            if (op_fire)
            begin
                op_kind_reg  <= op_kind;
                op_addr_reg  <= op_addr;
                op_esc_reg   <= op_esc;
                op_pos_reg   <= op_pos;
                fwd_hit_reg  <= op_valid_reg && (op_addr_reg == op_addr);
                fwd_data_reg <= rec_new;
            end
            if (op_valid_reg)
            begin
                vbit_reg[op_addr_reg] <= 1'b1;
            end

            // in ST_LOAD a free output register is always refilled below
            if (report_valid_reg && !report_stall && (state_reg != ST_LOAD))
            begin
                report_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                ST_RUN:
                begin
                    if (ch_take && is_term)
                    begin
                        state_reg     <= ST_READ;
                        walk_idx_reg  <= '0;
                        rpt_last_reg  <= last_idx[AW-1:0];
                        rpt_empty_reg <= !slot_active[0];
                        rpt_stop_reg  <= (phase_reg == PH_STOP) ? stopped_reg : pos_reg;
                        rpt_ovf_reg   <= ovf_reg;
                    end
                end
                ST_READ:
                begin
                    state_reg <= ST_LOAD;
                end
                ST_LOAD:
                begin
                    if (out_free)
                    begin
                        report_valid_reg    <= 1'b1;
                        entry_valid_reg     <= !rpt_empty_reg;
                        entry_index_reg     <= rpt_empty_reg ? '0
                                                             : cfp_pkg::INDEX_W'(walk_idx_reg);
                        out_rec_reg         <= walk_rec;
                        stop_position_reg   <= rpt_stop_reg;
                        length_overflow_reg <= rpt_ovf_reg;
                        last_report_reg     <= walk_last;
                        if (walk_last)
                        begin
                            // records start empty for the next text
                            vbit_reg  <= '0;
                            state_reg <= ST_RUN;
                        end
                        else
                        begin
                            walk_idx_reg <= walk_idx_reg + 1'b1;
                            state_reg    <= ST_READ;
                        end
                    end
                end
                default:
                begin
                    state_reg <= ST_RUN;
                end
            endcase
        end
    end

    assign report_valid    = report_valid_reg;
    assign entry_valid     = entry_valid_reg;
    assign entry_index     = entry_index_reg;
    assign present         = out_rec_reg[B_PRESENT];
    assign duplicated      = out_rec_reg[B_DUP];
    assign escaped_quote   = out_rec_reg[B_ESC];
    assign arg_given       = out_rec_reg[B_GIVEN];
    assign arg_start       = out_rec_reg[2*POS_W-1:POS_W];
    assign arg_length      = out_rec_reg[POS_W-1:0];
    assign stop_position   = stop_position_reg;
    assign length_overflow = length_overflow_reg;
    assign last_report     = last_report_reg;

endmodule

>>> design/cfp_ram.sv
`timescale 1ns / 1ps
module cfp_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 8,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> design/cfp_checker.sv
`timescale 1ns / 1ps
module cfp_checker #(
    parameter int POS_W = $clog2(cfp_pkg::MAX_LEN_DEFAULT + 1)
) (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        ch_valid,
    input logic                        ch_stall,
    input logic [cfp_pkg::CHAR_W-1:0]  ch,
    input logic                        report_valid,
    input logic                        report_stall,
    input logic                        entry_valid,
    input logic [cfp_pkg::INDEX_W-1:0] entry_index,
    input logic                        present,
    input logic                        arg_given,
    input logic [POS_W-1:0]            arg_start,
    input logic [POS_W-1:0]            arg_length,
    input logic                        last_report
);

    // a terminator request always starts the report walk
    assert property (@(posedge clk) disable iff (!rst_n)
        ch_valid && !ch_stall && (ch == cfp_pkg::CHAR_NUL) |=> ch_stall)
        else $error("terminator accepted but input not held off");

    assert property (@(posedge clk) disable iff (!rst_n)
        report_valid && report_stall |=> report_valid && $stable(entry_index)
            && $stable(arg_start) && $stable(arg_length) && $stable(last_report))
        else $error("stalled report changed");

    // empty table gives one bare report
    assert property (@(posedge clk) disable iff (!rst_n)
        report_valid && !entry_valid |-> last_report && (entry_index == '0)
            && !present && !arg_given)
        else $error("empty-table report malformed");

    assert property (@(posedge clk) disable iff (!rst_n)
        report_valid && !arg_given |-> (arg_start == '0))
        else $error("argument start set without argument");

endmodule

bind command_flag_parser cfp_checker #(.POS_W(POS_W)) u_cfp_checker (.*);
